>>> rtl/string_key_rank_sort_top_defines.svh
// ----------------------------------------------------------------------------
// string_key_rank_sort_top_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STRING_KEY_RANK_SORT_TOP_DEFINES_SVH
`define STRING_KEY_RANK_SORT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srks assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SRKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srks assertion failed");

`endif

>>> rtl/srks_pkg.sv
// ----------------------------------------------------------------------------
// srks_pkg
// Sizes, types and control bundles of the key rank sorter.
// ----------------------------------------------------------------------------
package srks_pkg;

  localparam int NUM_KEYS = 16;
  localparam int KEY_LEN  = 64;

  localparam int KIDX_W = $clog2(NUM_KEYS);
  localparam int CNT_W  = $clog2(NUM_KEYS + 1);
  localparam int POS_W  = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int LEN_W  = $clog2(KEY_LEN + 1);

  typedef logic [7:0]        byte_t;
  typedef logic [KIDX_W-1:0] kidx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam pos_t POS_LAST = pos_t'(KEY_LEN - 1);

  // load-side write bundle, shared by all cells
  typedef struct packed {
    pos_t  addr;
    byte_t data;
    len_t  len;
  } wr_t;

  // compare strobe, aligned with the registered key byte in each cell
  typedef struct packed {
    logic en;
    logic first;
    logic last;
    pos_t pos;
  } cmp_t;

  // sequencer to cell control
  typedef struct packed {
    logic cnt_clr;
    logic shr_load;
    logic shr_shift;
    pos_t rd_addr;
    cmp_t cmp;
  } ctl_t;

endpackage

>>> rtl/string_key_rank_sort_top.sv
// ----------------------------------------------------------------------------
// string_key_rank_sort_top
// Comparison-counting rank sort of short text keys on a row of key cells.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                           tlast       tuser
//  in_      in   [7:0] key_byte                  end_of_key  end_of_set
//  out_     out  [3:0] key_index, [7:4] rank     last_rank   -
//
//  in_tready is high whenever the block is idle or loading. After the word
//  with end_of_set, ranking steps through one byte position of one
//  reference key per cycle for each of the n loaded keys, compared in
//  every cell at once, then results leave one word per cycle while
//  out_tready is high.
//  rst_n clears the sequencer only; key bytes and lengths are not cleared.
//  Input is held off (in_tready low) while ranking and draining.
//
module string_key_rank_sort_top (
  input  logic       clk,
  input  logic       rst_n,
  // input words
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] key_byte
  input  logic       in_tlast,   // end_of_key
  input  logic       in_tuser,   // end_of_set
  // result words
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] key_index, [7:4] rank
  output logic       out_tlast   // last_rank
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RANK,
    S_FLUSH,
    S_COPY,
    S_OUT
  } state_t;

  state_t          state_r,     state_nxt;
  srks_pkg::cnt_t  loaded_r,    loaded_nxt;   // completed keys
  srks_pkg::len_t  bpos_r,      bpos_nxt;     // bytes kept for current key
  srks_pkg::cnt_t  n_r,         n_nxt;        // keys in the set being ranked
  srks_pkg::kidx_t ref_r,       ref_nxt;      // reference key being broadcast
  srks_pkg::pos_t  pos_r,       pos_nxt;      // byte position being read
  srks_pkg::kidx_t ref_d_r;                   // reference, aligned to read data
  srks_pkg::cmp_t  cmp_r,       cmp_nxt;
  srks_pkg::kidx_t out_idx_r,   out_idx_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;

  srks_pkg::len_t  bpos_inc;
  logic            wr_go;
  logic            len_go;
  logic            cnt_clr;
  logic            shr_load;
  logic            shr_shift;
  logic            idx_last;

  logic [srks_pkg::NUM_KEYS-1:0] wr_en;
  logic [srks_pkg::NUM_KEYS-1:0] len_we;

  srks_pkg::wr_t   wr_bus;
  srks_pkg::ctl_t  ctl;
  srks_pkg::byte_t ref_byte;
  srks_pkg::byte_t own_byte  [srks_pkg::NUM_KEYS];
  srks_pkg::kidx_t shr_chain [srks_pkg::NUM_KEYS+1];

  assign in_tready = (state_r == S_LOAD);
  assign idx_last  = (srks_pkg::cnt_t'(out_idx_r) + srks_pkg::cnt_t'(1) == n_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    bpos_nxt       = bpos_r;
    n_nxt          = n_r;
    ref_nxt        = ref_r;
    pos_nxt        = pos_r;
    cmp_nxt        = '0;
    out_idx_nxt    = out_idx_r;
    out_tvalid_nxt = out_tvalid_r;
    bpos_inc       = bpos_r;
    wr_go          = 1'b0;
    len_go         = 1'b0;
    cnt_clr        = 1'b0;
    shr_load       = 1'b0;
    shr_shift      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          // once every slot is full only end_of_set still counts
          if (loaded_r < srks_pkg::cnt_t'(srks_pkg::NUM_KEYS)) begin
            if (bpos_r < srks_pkg::len_t'(srks_pkg::KEY_LEN)) begin
              wr_go    = 1'b1;
              bpos_inc = bpos_r + srks_pkg::len_t'(1);
            end
            // end of set also closes the open key
            if (in_tlast || in_tuser) begin
              len_go     = 1'b1;
              loaded_nxt = loaded_r + srks_pkg::cnt_t'(1);
              bpos_nxt   = '0;
            end else begin
              bpos_nxt = bpos_inc;
            end
          end
          if (in_tuser) begin
            n_nxt      = loaded_nxt;
            loaded_nxt = '0;
            bpos_nxt   = '0;
            ref_nxt    = '0;
            pos_nxt    = '0;
            cnt_clr    = 1'b1;
            state_nxt  = S_RANK;
          end
        end
      end
      S_RANK: begin
        cmp_nxt.en    = 1'b1;
        cmp_nxt.first = (pos_r == '0);
        cmp_nxt.last  = (pos_r == srks_pkg::POS_LAST);
        cmp_nxt.pos   = pos_r;
        if (pos_r == srks_pkg::POS_LAST) begin
          pos_nxt = '0;
          if (srks_pkg::cnt_t'(ref_r) + srks_pkg::cnt_t'(1) == n_r) begin
            state_nxt = S_FLUSH;
          end else begin
            ref_nxt = ref_r + srks_pkg::kidx_t'(1);
          end
        end else begin
          pos_nxt = pos_r + srks_pkg::pos_t'(1);
        end
      end
      S_FLUSH: begin
        // last compare lands in the counters this cycle
        state_nxt = S_COPY;
      end
      S_COPY: begin
        shr_load       = 1'b1;
        out_idx_nxt    = '0;
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          shr_shift = 1'b1;
          if (idx_last) begin
            out_tvalid_nxt = 1'b0;
            state_nxt      = S_LOAD;
          end else begin
            out_idx_nxt = out_idx_r + srks_pkg::kidx_t'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      loaded_r     <= '0;
      bpos_r       <= '0;
      cmp_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_r     <= loaded_nxt;
      bpos_r       <= bpos_nxt;
      cmp_r        <= cmp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    ref_r     <= ref_nxt;
    pos_r     <= pos_nxt;
    ref_d_r   <= ref_r;
    out_idx_r <= out_idx_nxt;
  end

  // per-slot write strobes
  always_comb begin
    for (int k = 0; k < srks_pkg::NUM_KEYS; k++) begin
      wr_en[k]  = wr_go  && (loaded_r == srks_pkg::cnt_t'(k));
      len_we[k] = len_go && (loaded_r == srks_pkg::cnt_t'(k));
    end
  end

  assign wr_bus = '{addr: bpos_r[srks_pkg::POS_W-1:0], data: in_tdata, len: bpos_inc};

  assign ctl = '{cnt_clr:   cnt_clr,
                 shr_load:  shr_load,
                 shr_shift: shr_shift,
                 rd_addr:   pos_r,
                 cmp:       cmp_r};

  // reference byte: padded byte of the reference key's own cell
  assign ref_byte = own_byte[ref_d_r];

  assign shr_chain[srks_pkg::NUM_KEYS] = '0;

  for (genvar k = 0; k < srks_pkg::NUM_KEYS; k++) begin : g_cell
    srks_cell u_cell (
      .clk      (clk),
      .wr       (wr_bus),
      .wr_en    (wr_en[k]),
      .len_we   (len_we[k]),
      .ctl      (ctl),
      .ref_byte (ref_byte),
      .shr_in   (shr_chain[k+1]),
      .own_byte (own_byte[k]),
      .shr_out  (shr_chain[k])
    );
  end

  // cell 0 holds the rank of the key at out_idx_r
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'(shr_chain[0]), 4'(out_idx_r)};
  assign out_tlast  = idx_last;

endmodule

>>> rtl/srks_cell.sv
// ----------------------------------------------------------------------------
// srks_cell
// One key slot: key bytes, length, compare state, rank counter and a stage
// of the result shift chain.
// ----------------------------------------------------------------------------
module srks_cell (
  input  logic             clk,
  input  srks_pkg::wr_t    wr,
  input  logic             wr_en,
  input  logic             len_we,
  input  srks_pkg::ctl_t   ctl,
  input  srks_pkg::byte_t  ref_byte,
  input  srks_pkg::kidx_t  shr_in,
  output srks_pkg::byte_t  own_byte,
  output srks_pkg::kidx_t  shr_out
);

  srks_pkg::byte_t mem [srks_pkg::KEY_LEN];
  srks_pkg::byte_t q_r;
  srks_pkg::len_t  len_r;
  logic            decided_r;
  logic            gt_r;
  srks_pkg::kidx_t cnt_r;
  srks_pkg::kidx_t shr_r;

  logic dec_cur;
  logic gt_cur;
  logic gt_fin;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr.addr] <= wr.data;
    end
    q_r <= mem[ctl.rd_addr];
    if (len_we) begin
      len_r <= wr.len;
    end
  end

  // bytes past the stored length read as zero padding
  assign own_byte = (srks_pkg::len_t'(ctl.cmp.pos) < len_r) ? q_r : '0;

  assign dec_cur = ctl.cmp.first ? 1'b0 : decided_r;
  assign gt_cur  = ctl.cmp.first ? 1'b0 : gt_r;
  assign gt_fin  = dec_cur ? gt_cur : (own_byte > ref_byte);

  always_ff @(posedge clk) begin
    if (ctl.cmp.en) begin
      decided_r <= dec_cur | (own_byte != ref_byte);
      gt_r      <= gt_fin;
    end
    if (ctl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctl.cmp.en && ctl.cmp.last && gt_fin) begin
      cnt_r <= cnt_r + srks_pkg::kidx_t'(1);
    end
    if (ctl.shr_load) begin
      shr_r <= cnt_r;
    end else if (ctl.shr_shift) begin
      shr_r <= shr_in;
    end
  end

  assign shr_out = shr_r;

endmodule

>>> rtl/srks_checker.sv
// ----------------------------------------------------------------------------
// srks_checker
// Port-level checks of the key rank sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_key_rank_sort_top_defines.svh"

module srks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // loading and draining never overlap
  `SRKS_ASSERT_NOW(a_load_drain_excl, out_tvalid, !in_tready)

  // a stalled result word holds
  `SRKS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // end of set starts ranking: nothing in, nothing out on the next cycle
  `SRKS_ASSERT_NEXT(a_rank_start, in_tvalid && in_tready && in_tuser,
                    !in_tready && !out_tvalid)

  // results come in load order
  `SRKS_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_tlast,
                    out_tvalid && (out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1))

  // after the final result the block loads again
  `SRKS_ASSERT_NEXT(a_back_to_load, out_tvalid && out_tready && out_tlast,
                    in_tready && !out_tvalid)

endmodule

bind string_key_rank_sort_top srks_checker u_srks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/sv/string_key_rank_sort_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_key_rank_sort_top_tb
// Self-checking bench for the key rank sorter.
// Streams text keys into the block one byte per word and mirrors the load.
// On each end-of-set word it ranks the loaded keys by strict
// lexicographic order with zero padding, then checks every result word in
// order. Directed sets come first, then random sets, with random stalls on
// both sides.
// ----------------------------------------------------------------------------
module string_key_rank_sort_top_tb;

  localparam int WORD_TARGET   = 230;        // stop the random phase near here
  localparam int CYCLE_LIMIT   = 1_000_000;  // hard stop if the block hangs
  localparam int SETTLE_CYCLES = 64;         // quiet window after the last result
  localparam int MAX_GEN_KEYS  = 24;         // room for overflow sets
  localparam int MAX_GEN_LEN   = 72;         // longest generated key

  // one expected result word
  typedef struct packed {
    logic [3:0] key_index;
    logic [3:0] rank;
    logic       last_rank;
  } rank_word_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] key_byte
  logic       in_tlast   = 1'b0;   // end_of_key
  logic       in_tuser   = 1'b0;   // end_of_set
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [3:0] key_index, [7:4] rank
  logic       out_tlast;           // last_rank

  // mirror of the key storage, filled from accepted words
  srks_pkg::byte_t key_mem [srks_pkg::NUM_KEYS][srks_pkg::KEY_LEN];
  int              key_len [srks_pkg::NUM_KEYS];
  int              keys_held = 0;
  int              fill_pos  = 0;

  rank_word_t pending_ranks[$];

  int error_cnt  = 0;
  int cycle_cnt  = 0;
  int words_sent = 0;
  bit full_rate  = 1'b0;  // no gaps, no stalls while set

  // scratch keys for the generator
  srks_pkg::byte_t gen_key [MAX_GEN_KEYS][MAX_GEN_LEN];
  int              gen_len [MAX_GEN_KEYS];

  string_key_rank_sort_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("string_key_rank_sort_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // true when key a sorts strictly after key b; bytes past a key's length
  // count as zero, so trailing zero bytes never break a tie
  function automatic logic key_outranks(int a, int b);
    srks_pkg::byte_t x;
    srks_pkg::byte_t y;
    for (int p = 0; p < srks_pkg::KEY_LEN; p++) begin
      x = (p < key_len[a]) ? key_mem[a][p] : 8'h00;
      y = (p < key_len[b]) ? key_mem[b][p] : 8'h00;
      if (x != y) return x > y;
    end
    return 1'b0;
  endfunction

  // take one accepted word into the mirror; on set end queue one result
  // per key, rank = number of keys strictly below it
  function automatic void absorb_word(srks_pkg::byte_t b, logic eok, logic eos);
    int         below;
    rank_word_t w;
    // once the store is full, bytes and key ends fall on the floor
    if (keys_held < srks_pkg::NUM_KEYS) begin
      if (fill_pos < srks_pkg::KEY_LEN) begin
        key_mem[keys_held][fill_pos] = b;
        fill_pos++;
      end
      // set end closes the open key even without a key-end flag
      if (eok || eos) begin
        key_len[keys_held] = fill_pos;
        keys_held++;
        fill_pos = 0;
      end
    end
    if (eos) begin
      for (int i = 0; i < keys_held; i++) begin
        below = 0;
        for (int j = 0; j < keys_held; j++)
          if (key_outranks(i, j)) below++;
        w.key_index = 4'(i);
        w.rank      = 4'(below);
        w.last_rank = (i == keys_held - 1);
        pending_ranks.push_back(w);
      end
      keys_held = 0;
      fill_pos  = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) absorb_word(in_tdata, in_tlast, in_tuser);
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    rank_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result word: key_index %0d rank %0d last %0b",
                 $time, out_tdata[3:0], out_tdata[7:4], out_tlast);
        error_cnt++;
      end else begin
        want = pending_ranks.pop_front();
        if (out_tdata[3:0] !== want.key_index || out_tdata[7:4] !== want.rank ||
            out_tlast !== want.last_rank) begin
          $display("%0t: result mismatch: expected key_index %0d rank %0d last %0b, %s",
                   $time, want.key_index, want.rank, want.last_rank, "got");
          $display("%0t:   actual key_index %0d rank %0d last %0b",
                   $time, out_tdata[3:0], out_tdata[7:4], out_tlast);
          error_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side: always ready at full rate, else bursts of ready, then a stall of random length
  initial begin : drive_out_ready
    int run;
    int stall;
    forever begin
      if (full_rate) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        out_tready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // drive one word and hold it until the block takes it
  task automatic send_word(input srks_pkg::byte_t b, input logic eok, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eok;
    in_tuser  <= eos;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // idle the input and hold off until every queued result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Key generator: duplicates, prefixes and near misses are common so that
  // ties and close orderings show up often
  // --------------------------------------------------------------------------

  function automatic srks_pkg::byte_t pick_char();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFF;
      default: return srks_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void make_key(int k);
    int src;
    int r;
    int len;
    r   = $urandom_range(0, 9);
    src = (k > 0) ? $urandom_range(0, k - 1) : 0;
    if (k > 0 && r <= 4) begin
      len = gen_len[src];
      for (int p = 0; p < len; p++) gen_key[k][p] = gen_key[src][p];
      case (r)
        2: len = $urandom_range(1, len);                         // prefix
        3: gen_key[k][$urandom_range(0, len - 1)] = pick_char();  // near miss
        4: if (len <= MAX_GEN_LEN - 2) begin                      // zero tail
          gen_key[k][len]     = 8'h00;
          gen_key[k][len + 1] = 8'h00;
          len = len + $urandom_range(1, 2);
        end
        default: ;                                                // duplicate
      endcase
    end else begin
      // now and then a key near or past KEY_LEN to exercise truncation
      len = ($urandom_range(0, 47) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
      for (int p = 0; p < len; p++) gen_key[k][p] = pick_char();
    end
    gen_len[k] = len;
  endfunction

  // send nkeys generated keys as one set; the set end word drops its
  // key-end flag half the time, and keys past the store may lose theirs
  task automatic send_set(input int nkeys);
    logic last_byte;
    logic set_end;
    logic eok;
    for (int k = 0; k < nkeys; k++) begin
      make_key(k);
      for (int p = 0; p < gen_len[k]; p++) begin
        last_byte = (p == gen_len[k] - 1);
        set_end   = last_byte && (k == nkeys - 1);
        eok       = last_byte;
        if (set_end || (k >= srks_pkg::NUM_KEYS && last_byte)) begin
          eok = 1'($urandom_range(0, 1));
        end
        send_word(gen_key[k][p], eok, set_end);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // one key of one byte: rank 0, flagged last
  task automatic test_single_key();
    send_word(8'hFF, 1'b1, 1'b1);
  endtask

  // zero bytes are plain characters; [00] and [00 00] tie under padding;
  // set end closes the last key without a key-end flag
  task automatic test_zero_padding();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
  endtask

  // complementary bytes and the unsigned midpoint
  task automatic test_byte_extremes();
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'hAA, 1'b1, 1'b1);
  endtask

  // head byte, KEY_LEN-1 zeros and one nonzero extra byte: once the extra
  // byte is dropped the key ties with the one-byte key holding the head
  task automatic test_truncation();
    srks_pkg::byte_t head;
    head = srks_pkg::byte_t'($urandom_range(1, 255));
    send_word(head, 1'b0, 1'b0);
    for (int p = 1; p < srks_pkg::KEY_LEN; p++) send_word(8'h00, 1'b0, 1'b0);
    send_word(srks_pkg::byte_t'($urandom_range(1, 255)), 1'b1, 1'b0);
    send_word(head, 1'b1, 1'b1);
  endtask

  // a store filled to the last slot, with surplus keys that must be ignored
  task automatic test_key_overflow();
    send_set(srks_pkg::NUM_KEYS + 3);
  endtask

  // random sets; some at full rate, some followed by a full drain
  task automatic test_random_sets();
    int nkeys;
    while (words_sent < WORD_TARGET) begin
      nkeys = ($urandom_range(0, 9) == 0) ?
              $urandom_range(srks_pkg::NUM_KEYS + 1, srks_pkg::NUM_KEYS + 4) :
              $urandom_range(1, srks_pkg::NUM_KEYS);
      full_rate = ($urandom_range(0, 5) == 0);
      send_set(nkeys);
      if (full_rate || $urandom_range(0, 3) == 0) wait_drained();
      full_rate = 1'b0;
    end
  endtask

  // back-to-back sets with no gaps or stalls; sender waits for a full drain
  task automatic test_back_to_back();
    full_rate = 1'b1;
    send_set($urandom_range(3, 6));
    wait_drained();
    send_set($urandom_range(2, 4));
    wait_drained();
    full_rate = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_key();
    test_zero_padding();
    test_byte_extremes();
    test_truncation();
    test_key_overflow();
    test_random_sets();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("string_key_rank_sort_top verification clean");
    end else begin
      $display("string_key_rank_sort_top verification failed");
    end
    $finish;
  end

endmodule
